// ===== src/tcr_pkg.sv =====
// Shared types and constants for the text cell renderer.
// Depends on nothing; every other file imports it.
package tcr_pkg;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int GLYPHS        = 256;
    localparam int GLYPH_ROWS    = 8;
    localparam int PALETTE_DEPTH = 16;
    localparam int FONT_DEPTH    = GLYPHS * GLYPH_ROWS;
    localparam int FONT_AW       = $clog2(FONT_DEPTH);

    typedef enum logic [1:0] {
        OP_RENDER        = 2'd0,
        OP_FONT_WRITE    = 2'd1,
        OP_PALETTE_WRITE = 2'd2
    } op_t;

    typedef logic [23:0] color_t;

    localparam color_t EGA_COLORS [PALETTE_DEPTH] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    // Pixel request leaving the issue stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic [2:0] cy;
        logic [2:0] cx;
        logic [6:0] col;
        logic [4:0] row;
        color_t     fg;
        color_t     bg;
        logic       last;
    } pix_req_t;

    // Font row write from the input side.
    typedef struct packed {
        logic               en;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         data;
    } font_wr_t;

    // Pixel after the glyph row fetch.
    typedef struct packed {
        logic       valid;
        logic [9:0] x;
        logic [7:0] y;
        logic [2:0] cx;
        logic [7:0] row_bits;
        color_t     fg;
        color_t     bg;
        logic       last;
    } pix_fetch_t;

endpackage

// ===== src/tcr_issue.sv =====
// Input stage: decodes transactions, holds the palette, sequences 64 pixels per cell.
// Depends on tcr_pkg.
module tcr_issue
    import tcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_attribute,
    input  logic [6:0] s_cell_column,
    input  logic [4:0] s_cell_row,
    input  logic [2:0] s_glyph_row,
    input  logic [3:0] s_palette_index,
    input  logic [23:0] s_write_data,
    input  logic       advance,
    output pix_req_t   req,
    output font_wr_t   fwr
);

    logic       busy_reg, busy_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [7:0] code_reg;
    logic [6:0] col_reg;
    logic [4:0] row_reg;
    color_t     fg_reg, bg_reg;
    color_t     palette_reg [PALETTE_DEPTH];

    logic accept, issue, is_render, is_font, is_pal, in_screen, start;

    assign accept    = s_valid && s_ready;
    assign issue     = busy_reg && advance;
    // last pixel of a cell leaves this cycle: room for the next transaction
    assign s_ready   = !busy_reg || (issue && (&cnt_reg));
    assign in_screen = (int'(s_cell_column) < COLUMNS) && (int'(s_cell_row) < ROWS);
    assign start     = accept && is_render && in_screen;

    always_comb begin
        is_render = 1'b0;
        is_font   = 1'b0;
        is_pal    = 1'b0;
        case (op_t'(s_operation))
            OP_RENDER:        is_render = 1'b1;
            OP_FONT_WRITE:    is_font   = 1'b1;
            OP_PALETTE_WRITE: is_pal    = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (issue) begin
            cnt_next = cnt_reg + 6'd1;
            if (&cnt_reg) busy_next = 1'b0;
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // cell payload; colors looked up once per cell
    always_ff @(posedge aclk) begin
        if (start) begin
            code_reg <= s_char_code;
            col_reg  <= s_cell_column;
            row_reg  <= s_cell_row;
            fg_reg   <= palette_reg[s_attribute[3:0]];
            bg_reg   <= palette_reg[s_attribute[7:4]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_DEPTH; i++) palette_reg[i] <= EGA_COLORS[i];
        end else if (accept && is_pal) begin
            palette_reg[s_palette_index] <= s_write_data;
        end
    end

    assign fwr.en   = accept && is_font;
    assign fwr.addr = {s_char_code, s_glyph_row};
    assign fwr.data = s_write_data[7:0];

    assign req.valid = busy_reg;
    assign req.code  = code_reg;
    assign req.cy    = cnt_reg[5:3];
    assign req.cx    = cnt_reg[2:0];
    assign req.col   = col_reg;
    assign req.row   = row_reg;
    assign req.fg    = fg_reg;
    assign req.bg    = bg_reg;
    assign req.last  = &cnt_reg;

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && advance && !(&cnt_reg) |=> busy_reg && cnt_reg == $past(cnt_reg) + 6'd1)
        else $error("pixel counter skipped or cell ended early");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !advance |=> busy_reg && $stable(cnt_reg))
        else $error("pixel counter moved during stall");

    a_cell_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == 6'd0)
        else $error("render transaction did not start a cell");

endmodule

// ===== src/tcr_fetch.sv =====
// Glyph row fetch: font RAM with registered read, plus coordinate stage.
// Depends on tcr_pkg.
module tcr_fetch
    import tcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  pix_req_t   req,
    input  font_wr_t   fwr,
    output pix_fetch_t fet
);

    logic [7:0] font_mem [FONT_DEPTH];
    logic       valid_reg;
    logic [7:0] bits_reg;
    logic [9:0] x_reg;
    logic [7:0] y_reg;
    logic [2:0] cx_reg;
    color_t     fg_reg, bg_reg;
    logic       last_reg;

    always_ff @(posedge aclk) begin
        if (fwr.en) font_mem[fwr.addr] <= fwr.data;
    end

    always_ff @(posedge aclk) begin
        if (advance) bits_reg <= font_mem[{req.code, req.cy}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (advance) valid_reg <= req.valid;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg    <= {req.col, req.cx};
            y_reg    <= {req.row, req.cy};
            cx_reg   <= req.cx;
            fg_reg   <= req.fg;
            bg_reg   <= req.bg;
            last_reg <= req.last;
        end
    end

    assign fet.valid    = valid_reg;
    assign fet.x        = x_reg;
    assign fet.y        = y_reg;
    assign fet.cx       = cx_reg;
    assign fet.row_bits = bits_reg;
    assign fet.fg       = fg_reg;
    assign fet.bg       = bg_reg;
    assign fet.last     = last_reg;

endmodule

// ===== src/tcr_shade.sv =====
// Output stage: picks foreground or background per pixel, holds the result register.
// Depends on tcr_pkg.
module tcr_shade
    import tcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pix_fetch_t fet,
    output logic       advance,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [9:0] m_pixel_x,
    output logic [7:0] m_pixel_y,
    output logic [23:0] m_pixel_color,
    output logic       m_last_pixel
);

    logic       valid_reg;
    logic [9:0] x_reg;
    logic [7:0] y_reg;
    color_t     color_reg;
    logic       last_reg;

    assign advance = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (advance) valid_reg <= fet.valid;
    end

    // leftmost pixel sits in bit 7, so bit index is ~cx
    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg     <= fet.x;
            y_reg     <= fet.y;
            color_reg <= fet.row_bits[~fet.cx] ? fet.fg : fet.bg;
            last_reg  <= fet.last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_pixel_x     = x_reg;
    assign m_pixel_y     = y_reg;
    assign m_pixel_color = color_reg;
    assign m_last_pixel  = last_reg;

endmodule

// ===== src/text_cell_renderer.sv =====
// Top level of the 8x8 text cell renderer.
// Depends on tcr_pkg, tcr_issue, tcr_fetch, tcr_shade.
//
// Usage: every input transaction carries an operation. A font write stores one
// 8-bit glyph row (bit 7 is the leftmost pixel) and a palette write stores one
// 0xRRGGBB color; neither gives any output. A render transaction for a cell on
// the 80x25 screen emits 64 pixel transactions, glyph row by glyph row, left to
// right, with last_pixel on the 64th; a cell off the screen and the unused
// operation code are dropped. Pixels come out at one per clock while m_ready
// does not stall, a rate set by the single output pixel per clock and the one
// read port of the font RAM; the next transaction is taken in the cycle the
// last pixel of a cell is issued. The first pixel of a render passes the issue
// counter, which loads on the accepting edge, then the font fetch register,
// then the output register. Stalls on m_ready freeze the whole pipeline;
// nothing is dropped. The palette resets to the EGA colors; font RAM is not
// cleared, so each glyph row must be written before any cell that uses it is
// rendered. Palette colors are sampled when the render is accepted; font rows
// are read per glyph row as pixels are issued, and writes accepted after a
// render never affect its pixels.
module text_cell_renderer
    import tcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_attribute,
    input  logic [6:0]  s_cell_column,
    input  logic [4:0]  s_cell_row,
    input  logic [2:0]  s_glyph_row,
    input  logic [3:0]  s_palette_index,
    input  logic [23:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_pixel_x,
    output logic [7:0]  m_pixel_y,
    output logic [23:0] m_pixel_color,
    output logic        m_last_pixel
);

    logic       advance;   // whole pipeline moves together
    pix_req_t   req;
    font_wr_t   fwr;
    pix_fetch_t fet;

    // stage 0: decode, palette, per-cell pixel counter
    tcr_issue u_issue (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_char_code     (s_char_code),
        .s_attribute     (s_attribute),
        .s_cell_column   (s_cell_column),
        .s_cell_row      (s_cell_row),
        .s_glyph_row     (s_glyph_row),
        .s_palette_index (s_palette_index),
        .s_write_data    (s_write_data),
        .advance         (advance),
        .req             (req),
        .fwr             (fwr)
    );

    // stage 1: glyph row read, screen coordinates
    tcr_fetch u_fetch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .req     (req),
        .fwr     (fwr),
        .fet     (fet)
    );

    // stage 2: color select into the output register
    tcr_shade u_shade (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fet           (fet),
        .advance       (advance),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last_pixel  (m_last_pixel)
    );

endmodule
